@@ rtl/du3_pkg.sv @@
// Shared types and constants for the 3D distance unit.
// No dependencies; every other file in rtl imports this package.
package du3_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int DIST_W         = 35;
    localparam int RADIUS_W       = 31;
    localparam int FUNC_W         = 2;
    localparam int FRONT_STAGES   = 6;

    localparam logic [FUNC_W-1:0] FUNC_POINT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LINE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SPHERE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [RADIUS_W-1:0] radius;
        logic                degen;
    } ctrl_t;

endpackage

@@ rtl/du3_front.sv @@
// Front pipeline: differences, products, cross terms and sums of squares.
// Six register stages; uses du3_pkg.
module du3_front
    import du3_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [FUNC_W-1:0]       func,
    input  logic [COORD_BITS-1:0]   point_x,
    input  logic [COORD_BITS-1:0]   point_y,
    input  logic [COORD_BITS-1:0]   point_z,
    input  logic [COORD_BITS-1:0]   first_x,
    input  logic [COORD_BITS-1:0]   first_y,
    input  logic [COORD_BITS-1:0]   first_z,
    input  logic [COORD_BITS-1:0]   second_x,
    input  logic [COORD_BITS-1:0]   second_y,
    input  logic [COORD_BITS-1:0]   second_z,
    input  logic [RADIUS_W-1:0]     sphere_radius,
    output logic [2*COORD_BITS+3:0] dsum,
    output logic [2*COORD_BITS+3:0] usum,
    output logic [4*COORD_BITS+5:0] csum,
    output ctrl_t                   ctrl
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int PW = 2 * DW;
    localparam int SW = 2 * C + 4;
    localparam int H  = DW;
    localparam int QW = 4 * H;
    localparam int CW = 4 * C + 6;

    // stage 1
    logic signed [DW-1:0] l_reg [3];
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] l_next [3];
    logic signed [DW-1:0] u_next [3];
    ctrl_t                c1_reg;
    ctrl_t                c1_next;

    // stage 2
    logic signed [PW-1:0] lsq_reg [3];
    logic signed [PW-1:0] usq_reg [3];
    logic signed [PW-1:0] p_reg [6];
    logic signed [PW-1:0] lsq_next [3];
    logic signed [PW-1:0] usq_next [3];
    logic signed [PW-1:0] p_next [6];
    ctrl_t                c2_reg;
    ctrl_t                c2_next;

    // stage 3
    logic [SW-1:0]        d3_reg;
    logic [SW-1:0]        u3_reg;
    logic [PW-1:0]        cm_reg [3];
    logic [SW-1:0]        d3_next;
    logic [SW-1:0]        u3_next;
    logic [PW-1:0]        cm_next [3];
    logic signed [PW:0]   cdiff [3];
    ctrl_t                c3_reg;

    // stage 4
    logic [SW-1:0]        d4_reg;
    logic [SW-1:0]        u4_reg;
    logic [2*H-1:0]       hh_reg [3];
    logic [2*H-1:0]       hl_reg [3];
    logic [2*H-1:0]       ll_reg [3];
    logic [2*H-1:0]       hh_next [3];
    logic [2*H-1:0]       hl_next [3];
    logic [2*H-1:0]       ll_next [3];
    ctrl_t                c4_reg;

    // stage 5
    logic [SW-1:0]        d5_reg;
    logic [SW-1:0]        u5_reg;
    logic [QW-1:0]        sq_reg [3];
    logic [QW-1:0]        sq_next [3];
    ctrl_t                c5_reg;

    // stage 6
    logic [SW-1:0]        d6_reg;
    logic [SW-1:0]        u6_reg;
    logic [CW-1:0]        cs_reg;
    logic [CW-1:0]        cs_next;
    ctrl_t                c6_reg;

    always_comb
    begin
        l_next[0] = {point_x[C-1], point_x} - {first_x[C-1], first_x};
        l_next[1] = {point_y[C-1], point_y} - {first_y[C-1], first_y};
        l_next[2] = {point_z[C-1], point_z} - {first_z[C-1], first_z};
        u_next[0] = {second_x[C-1], second_x} - {first_x[C-1], first_x};
        u_next[1] = {second_y[C-1], second_y} - {first_y[C-1], first_y};
        u_next[2] = {second_z[C-1], second_z} - {first_z[C-1], first_z};
        c1_next.func   = func;
        c1_next.radius = sphere_radius;
        c1_next.degen  = 1'b0;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lsq_next[i] = l_reg[i] * l_reg[i];
            usq_next[i] = u_reg[i] * u_reg[i];
        end
        p_next[0] = l_reg[1] * u_reg[2];
        p_next[1] = l_reg[2] * u_reg[1];
        p_next[2] = l_reg[2] * u_reg[0];
        p_next[3] = l_reg[0] * u_reg[2];
        p_next[4] = l_reg[0] * u_reg[1];
        p_next[5] = l_reg[1] * u_reg[0];
        c2_next       = c1_reg;
        c2_next.degen = (u_reg[0] == '0) && (u_reg[1] == '0) && (u_reg[2] == '0);
    end

    always_comb
    begin
        d3_next = SW'(unsigned'(lsq_reg[0])) + SW'(unsigned'(lsq_reg[1]))
                + SW'(unsigned'(lsq_reg[2]));
        u3_next = SW'(unsigned'(usq_reg[0])) + SW'(unsigned'(usq_reg[1]))
                + SW'(unsigned'(usq_reg[2]));
        for (int i = 0; i < 3; i++)
        begin
            cdiff[i]   = {p_reg[2*i][PW-1], p_reg[2*i]}
                       - {p_reg[2*i+1][PW-1], p_reg[2*i+1]};
            cm_next[i] = cdiff[i][PW] ? PW'(-cdiff[i]) : cdiff[i][PW-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hh_next[i] = cm_reg[i][PW-1:H] * cm_reg[i][PW-1:H];
            hl_next[i] = cm_reg[i][PW-1:H] * cm_reg[i][H-1:0];
            ll_next[i] = cm_reg[i][H-1:0] * cm_reg[i][H-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = {hh_reg[i], {(2*H){1'b0}}}
                       + (QW'(hl_reg[i]) << (H + 1))
                       + QW'(ll_reg[i]);
        end
        cs_next = CW'(sq_reg[0]) + CW'(sq_reg[1]) + CW'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg   <= l_next;
            u_reg   <= u_next;
            c1_reg  <= c1_next;
            lsq_reg <= lsq_next;
            usq_reg <= usq_next;
            p_reg   <= p_next;
            c2_reg  <= c2_next;
            d3_reg  <= d3_next;
            u3_reg  <= u3_next;
            cm_reg  <= cm_next;
            c3_reg  <= c2_reg;
            d4_reg  <= d3_reg;
            u4_reg  <= u3_reg;
            hh_reg  <= hh_next;
            hl_reg  <= hl_next;
            ll_reg  <= ll_next;
            c4_reg  <= c3_reg;
            d5_reg  <= d4_reg;
            u5_reg  <= u4_reg;
            sq_reg  <= sq_next;
            c5_reg  <= c4_reg;
            d6_reg  <= d5_reg;
            u6_reg  <= u5_reg;
            cs_reg  <= cs_next;
            c6_reg  <= c5_reg;
        end
    end

    assign dsum = d6_reg;
    assign usum = u6_reg;
    assign csum = cs_reg;
    assign ctrl = c6_reg;

endmodule

@@ rtl/du3_sqrt_cell.sv @@
// One cell of the square root row: settles one root bit per cycle while en is high.
// Carries a side payload alongside; uses du3_pkg.
module du3_sqrt_cell
    import du3_pkg::*;
#(
    parameter int RAD_W  = 2 * COORD_BITS_DEF + 4,
    parameter int SIDE_W = 1
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [RAD_W-1:0]     rad_in,
    input  logic [RAD_W/2+1:0]   rem_in,
    input  logic [RAD_W/2-1:0]   root_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic [RAD_W-1:0]     rad_out,
    output logic [RAD_W/2+1:0]   rem_out,
    output logic [RAD_W/2-1:0]   root_out,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        rem_sh    = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        trial     = {root_in, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[ROOT_W-2:0], ge};
        rad_next  = rad_in << 2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

@@ rtl/du3_div_cell.sv @@
// One cell of the divider row: settles one quotient bit per cycle while en is high.
// Carries divisor and side payload alongside; uses du3_pkg.
module du3_div_cell
    import du3_pkg::*;
#(
    parameter int NUM_W  = 2 * COORD_BITS_DEF + 3,
    parameter int DEN_W  = COORD_BITS_DEF + 2,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [DEN_W-1:0]  rem_in,
    input  logic [NUM_W-1:0]  quo_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic [NUM_W-1:0]  num_out,
    output logic [DEN_W-1:0]  rem_out,
    output logic [NUM_W-1:0]  quo_out,
    output logic [DEN_W-1:0]  den_out,
    output logic [SIDE_W-1:0] side_out
);

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              ge;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  den_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        rem_sh   = {rem_in, num_in[NUM_W-1]};
        rem_sub  = rem_sh - {1'b0, den_in};
        ge       = (rem_sh >= {1'b0, den_in});
        rem_next = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_next = {quo_in[NUM_W-2:0], ge};
        num_next = num_in << 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_in;
            side_reg <= side_in;
        end
    end

    assign num_out  = num_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign den_out  = den_reg;
    assign side_out = side_reg;

endmodule

@@ rtl/distance_unit_3d.sv @@
// Top level of the 3D distance unit: front pipeline, square root rows,
// divider row and output register. Uses du3_pkg and all du3_* cells.
//
//  channel | direction | handshake            | payload
//  item    | in        | item_valid/item_stall | func, point_*, first_*, second_*, sphere_radius
//  result  | out       | result_valid/result_stall | distance, status
//
// One item per cycle while no result is held; an item passes the front pipeline,
// the cross-norm root row, the divider row (one bit per cell) and the output register.
// Reset clears only the valid line and the output valid.
// A held result freezes the whole pipeline; item_stall follows it.
module distance_unit_3d
    import du3_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [FUNC_W-1:0]     func,
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    input  logic [COORD_BITS-1:0] point_z,
    input  logic [COORD_BITS-1:0] first_x,
    input  logic [COORD_BITS-1:0] first_y,
    input  logic [COORD_BITS-1:0] first_z,
    input  logic [COORD_BITS-1:0] second_x,
    input  logic [COORD_BITS-1:0] second_y,
    input  logic [COORD_BITS-1:0] second_z,
    input  logic [RADIUS_W-1:0]   sphere_radius,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [DIST_W-1:0]     distance,
    output logic                  status
);

    localparam int C       = COORD_BITS;
    localparam int RW_N    = 2 * C + 4;
    localparam int ROOT_N  = RW_N / 2;
    localparam int REM_N   = ROOT_N + 2;
    localparam int RW_C    = 4 * C + 6;
    localparam int ROOT_C  = RW_C / 2;
    localparam int REM_C   = ROOT_C + 2;
    localparam int NUM_W   = ROOT_C;
    localparam int DEN_W   = ROOT_N;
    localparam int CTRL_W  = $bits(ctrl_t);
    localparam int DSIDE_W = FUNC_W + RADIUS_W;
    localparam int XSIDE_W = 2 * ROOT_N + CTRL_W;
    localparam int VSIDE_W = ROOT_N + CTRL_W;
    localparam int LAT     = FRONT_STAGES + ROOT_C + NUM_W;
    localparam int EXT_W   = NUM_W;
    localparam logic [EXT_W-1:0] DistMax = EXT_W'({DIST_W{1'b1}});

    logic                  adv;
    logic [LAT-1:0]        v_reg, v_next;
    logic                  result_valid_reg;
    logic [DIST_W-1:0]     dist_reg, dist_next;
    logic                  status_reg, status_next;

    logic [RW_N-1:0]       dsum, usum;
    logic [RW_C-1:0]       csum;
    ctrl_t                 fctrl;

    logic [RW_N-1:0]       dn_rad  [ROOT_N+1];
    logic [REM_N-1:0]      dn_rem  [ROOT_N+1];
    logic [ROOT_N-1:0]     dn_root [ROOT_N+1];
    logic [DSIDE_W-1:0]    dn_side [ROOT_N+1];
    logic [RW_N-1:0]       un_rad  [ROOT_N+1];
    logic [REM_N-1:0]      un_rem  [ROOT_N+1];
    logic [ROOT_N-1:0]     un_root [ROOT_N+1];
    logic                  un_side [ROOT_N+1];

    logic [RW_C-1:0]       xs_rad  [ROOT_C+1];
    logic [REM_C-1:0]      xs_rem  [ROOT_C+1];
    logic [ROOT_C-1:0]     xs_root [ROOT_C+1];
    logic [XSIDE_W-1:0]    xs_side [ROOT_C+1];
    logic [XSIDE_W-1:0]    junction;
    ctrl_t                 jctrl;

    logic [NUM_W-1:0]      dv_num  [NUM_W+1];
    logic [DEN_W-1:0]      dv_rem  [NUM_W+1];
    logic [NUM_W-1:0]      dv_quo  [NUM_W+1];
    logic [DEN_W-1:0]      dv_den  [NUM_W+1];
    logic [VSIDE_W-1:0]    dv_side [NUM_W+1];

    logic [ROOT_N-1:0]     fin_dnorm;
    ctrl_t                 fin_ctrl;
    logic [EXT_W-1:0]      ext_d, ext_r, ext_q, ext_s;

    assign adv        = !result_valid_reg || !result_stall;
    assign item_stall = !adv;

    du3_front #(.COORD_BITS(COORD_BITS)) u_front
    (
        .clk           (clk),
        .en            (adv),
        .func          (func),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .first_x       (first_x),
        .first_y       (first_y),
        .first_z       (first_z),
        .second_x      (second_x),
        .second_y      (second_y),
        .second_z      (second_z),
        .sphere_radius (sphere_radius),
        .dsum          (dsum),
        .usum          (usum),
        .csum          (csum),
        .ctrl          (fctrl)
    );

    assign dn_rad[0]  = dsum;
    assign dn_rem[0]  = '0;
    assign dn_root[0] = '0;
    assign dn_side[0] = {fctrl.func, fctrl.radius};
    assign un_rad[0]  = usum;
    assign un_rem[0]  = '0;
    assign un_root[0] = '0;
    assign un_side[0] = fctrl.degen;

    for (genvar g = 0; g < ROOT_N; g++)
    begin : g_norm
        du3_sqrt_cell #(.RAD_W(RW_N), .SIDE_W(DSIDE_W)) u_dcell
        (
            .clk      (clk),
            .en       (adv),
            .rad_in   (dn_rad[g]),
            .rem_in   (dn_rem[g]),
            .root_in  (dn_root[g]),
            .side_in  (dn_side[g]),
            .rad_out  (dn_rad[g+1]),
            .rem_out  (dn_rem[g+1]),
            .root_out (dn_root[g+1]),
            .side_out (dn_side[g+1])
        );
        du3_sqrt_cell #(.RAD_W(RW_N), .SIDE_W(1)) u_ucell
        (
            .clk      (clk),
            .en       (adv),
            .rad_in   (un_rad[g]),
            .rem_in   (un_rem[g]),
            .root_in  (un_root[g]),
            .side_in  (un_side[g]),
            .rad_out  (un_rad[g+1]),
            .rem_out  (un_rem[g+1]),
            .root_out (un_root[g+1]),
            .side_out (un_side[g+1])
        );
    end

    always_comb
    begin
        jctrl.func   = dn_side[ROOT_N][DSIDE_W-1 -: FUNC_W];
        jctrl.radius = dn_side[ROOT_N][RADIUS_W-1:0];
        jctrl.degen  = un_side[ROOT_N];
        junction     = {dn_root[ROOT_N], un_root[ROOT_N], jctrl};
    end

    assign xs_rad[0]  = csum;
    assign xs_rem[0]  = '0;
    assign xs_root[0] = '0;
    assign xs_side[0] = '0;

    for (genvar g = 0; g < ROOT_C; g++)
    begin : g_cross
        logic [XSIDE_W-1:0] side_in;
        if (g == ROOT_N)
        begin : g_join
            assign side_in = junction;
        end
        else
        begin : g_pass
            assign side_in = xs_side[g];
        end
        du3_sqrt_cell #(.RAD_W(RW_C), .SIDE_W(XSIDE_W)) u_xcell
        (
            .clk      (clk),
            .en       (adv),
            .rad_in   (xs_rad[g]),
            .rem_in   (xs_rem[g]),
            .root_in  (xs_root[g]),
            .side_in  (side_in),
            .rad_out  (xs_rad[g+1]),
            .rem_out  (xs_rem[g+1]),
            .root_out (xs_root[g+1]),
            .side_out (xs_side[g+1])
        );
    end

    assign dv_num[0]  = xs_root[ROOT_C];
    assign dv_rem[0]  = '0;
    assign dv_quo[0]  = '0;
    assign dv_den[0]  = xs_side[ROOT_C][XSIDE_W-ROOT_N-1 -: ROOT_N];
    assign dv_side[0] = {xs_side[ROOT_C][XSIDE_W-1 -: ROOT_N],
                         xs_side[ROOT_C][CTRL_W-1:0]};

    for (genvar g = 0; g < NUM_W; g++)
    begin : g_div
        du3_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(VSIDE_W)) u_vcell
        (
            .clk      (clk),
            .en       (adv),
            .num_in   (dv_num[g]),
            .rem_in   (dv_rem[g]),
            .quo_in   (dv_quo[g]),
            .den_in   (dv_den[g]),
            .side_in  (dv_side[g]),
            .num_out  (dv_num[g+1]),
            .rem_out  (dv_rem[g+1]),
            .quo_out  (dv_quo[g+1]),
            .den_out  (dv_den[g+1]),
            .side_out (dv_side[g+1])
        );
    end

    always_comb
    begin
        fin_dnorm = dv_side[NUM_W][VSIDE_W-1 -: ROOT_N];
        fin_ctrl  = dv_side[NUM_W][CTRL_W-1:0];
        ext_d     = EXT_W'(fin_dnorm);
        ext_r     = EXT_W'(fin_ctrl.radius);
        ext_q     = dv_quo[NUM_W];
        ext_s     = (ext_d >= ext_r) ? (ext_d - ext_r) : (ext_r - ext_d);
        dist_next   = '0;
        status_next = 1'b0;
        case (fin_ctrl.func)
            FUNC_POINT:
                dist_next = (ext_d > DistMax) ? DistMax[DIST_W-1:0] : ext_d[DIST_W-1:0];
            FUNC_LINE:
                if (fin_ctrl.degen)
                    status_next = 1'b1;
                else
                    dist_next = (ext_q > DistMax) ? DistMax[DIST_W-1:0]
                                                  : ext_q[DIST_W-1:0];
            FUNC_SPHERE:
                dist_next = (ext_s > DistMax) ? DistMax[DIST_W-1:0] : ext_s[DIST_W-1:0];
            default:
                dist_next = '0;
        endcase
        v_next = {v_reg[LAT-2:0], item_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg            <= v_next;
            result_valid_reg <= v_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg   <= dist_next;
            status_reg <= status_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign distance     = dist_reg;
    assign status       = status_reg;

endmodule

@@ rtl/du3_checker.sv @@
// Port-level checks for distance_unit_3d, attached by the bind below.
// Uses du3_pkg for field widths.
module du3_checker
    import du3_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input logic [DIST_W-1:0] distance,
    input logic              status
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(distance) && $stable(status))
        else $error("stalled result beat changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled while output free");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> distance == '0)
        else $error("degenerate line beat with nonzero distance");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid during reset");

endmodule

bind distance_unit_3d du3_checker u_du3_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .distance     (distance),
    .status       (status)
);
